// File: rtl/sobel_edge_magnitude_defines.svh
// ----------------------------------------------------------------------------
// sobel edge magnitude assertion macros
// shared checking helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

`ifndef SYNTH
// property that must hold on every clock outside reset
`define SEM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication checked on the same clock
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SEM_ASSERT_ALWAYS(lbl, expr, msg)
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared widths, register indexes and reset values of the sobel block
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_CHANNELS = 4;

  // field and register widths
  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 13;
  localparam int CCNT_W   = 3;
  localparam int ROW_W    = 14;
  localparam int GRAD_W   = 11;
  localparam int SQ_W     = 2 * GRAD_W;
  localparam int RAD_W    = 16;
  localparam int ROOT_W   = 8;

  // register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_WIDTH   = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT  = 2'd1;
  localparam cfg_idx_t REG_CHANNEL_COUNT = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH   = 13'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = 3'd1;

endpackage

`default_nettype wire

// File: rtl/sem_line_store.sv
// ----------------------------------------------------------------------------
// sem_line_store
// two-row sample memory, two registered read ports and one write port
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_store #(
  parameter int ADDR_W = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           rd_top_addr,
  input  wire logic [ADDR_W-1:0]           rd_mid_addr,
  output logic      [sem_pkg::SAMPLE_W-1:0] rd_top_data,
  output logic      [sem_pkg::SAMPLE_W-1:0] rd_mid_data,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [sem_pkg::SAMPLE_W-1:0] wr_data
);

  logic [sem_pkg::SAMPLE_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top_data <= mem[rd_top_addr];
      rd_mid_data <= mem[rd_mid_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sem_isqrt.sv
// ----------------------------------------------------------------------------
// sem_isqrt
// serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sem_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [sem_pkg::RAD_W-1:0]  value,
  output logic                            done,
  output logic      [sem_pkg::ROOT_W-1:0] root
);

  localparam int REM_W = sem_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(sem_pkg::ROOT_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [sem_pkg::RAD_W-1:0]  val_r;
  logic [REM_W-1:0]           rem_r;
  logic [sem_pkg::ROOT_W-1:0] root_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one digit pair per step
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], val_r[sem_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(sem_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[sem_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[sem_pkg::ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// streaming 3x3 sobel gradient magnitude over interleaved channels
// ----------------------------------------------------------------------------
// Samples arrive in raster order, channels interleaved; each channel is filtered
// on its own with edge pixels repeated at the borders. A result is floor(sqrt(
// gx^2+gy^2)) saturated at 255 and appears one row plus one pixel after its
// sample; drain beats push out the last row and the frame's final result carries
// frame_end. One item is worked at a time: a beat with a result passes through
// accept with the line store read, window update, gradient, square, root start,
// the serial square root and output load, which waits while the previous result
// is held; a beat with no result passes through accept and window update, and a
// drain beat inside the frame is dropped at accept. A finished result waits in
// the output register while the next beat is taken. The line store is never
// cleared; unwritten entries only feed border positions that are replaced. A
// write to a defined register while idle restarts the frame.
`default_nettype none

`include "sobel_edge_magnitude_defines.svh"

module sobel_edge_magnitude #(
  parameter int MAX_WIDTH    = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = sem_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [sem_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sem_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                         in_drain,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [sem_pkg::SAMPLE_W-1:0] out_magnitude,
  output logic                              out_frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int CEFF_W = $clog2(MAX_CHANNELS + 1);
  localparam int ADDR_W = 1 + COL_W + CH_W;
  localparam int SW     = sem_pkg::SAMPLE_W;
  localparam int GW     = sem_pkg::GRAD_W;
  localparam int ROW_W  = sem_pkg::ROW_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MEM, ST_GRAD, ST_SQ, ST_START, ST_ROOT, ST_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [sem_pkg::CFG_W-1:0]  fw_r, fh_r;
  logic [sem_pkg::CCNT_W-1:0] cc_r;

  // position counters
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [CH_W-1:0]  in_ch_r, out_ch_r;

  // per-item context
  logic [SW-1:0]     s_r;
  logic [CH_W-1:0]   ch_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              emit_r, edge_r, ldup_r, tdup_r, bdup_r, last_r;

  // window [channel][row][column]
  logic [SW-1:0] win_r [MAX_CHANNELS][3][3];

  logic signed [GW-1:0]  gx_r, gy_r;
  logic [sem_pkg::RAD_W-1:0] sq_r;
  logic                  sat_r;

  logic              out_valid_r, out_frame_end_r;
  logic [SW-1:0]     out_mag_r;

  // effective register values
  logic [WEFF_W-1:0]         w_eff;
  logic [sem_pkg::CFG_W-1:0] h_eff;
  logic [CEFF_W-1:0]         c_eff;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (15'(fw_r) > 15'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(fw_r);
    end
    h_eff = (fh_r == '0) ? sem_pkg::CFG_W'(1) : fh_r;
    if (cc_r == '0) begin
      c_eff = CEFF_W'(1);
    end else if (4'(cc_r) > 4'(MAX_CHANNELS)) begin
      c_eff = CEFF_W'(MAX_CHANNELS);
    end else begin
      c_eff = CEFF_W'(cc_r);
    end
  end

  // position decode of the incoming beat
  logic accept, in_frame, drop, emit, edge_pos, in_ch_wrap, in_col_wrap;
  logic out_ch_wrap, out_row_last, last;

  always_comb begin
    accept       = in_valid && !in_stall;
    in_frame     = in_row_r < ROW_W'(h_eff);
    drop         = in_frame && in_drain;
    emit         = (in_row_r > ROW_W'(1)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    edge_pos     = (WEFF_W+1)'(out_col_r) + 1'b1 >= (WEFF_W+1)'(w_eff);
    in_ch_wrap   = (CEFF_W+1)'(in_ch_r) + 1'b1 >= (CEFF_W+1)'(c_eff);
    in_col_wrap  = (WEFF_W+1)'(in_col_r) + 1'b1 >= (WEFF_W+1)'(w_eff);
    out_ch_wrap  = (CEFF_W+1)'(out_ch_r) + 1'b1 >= (CEFF_W+1)'(c_eff);
    out_row_last = out_row_r + 1'b1 >= ROW_W'(h_eff);
    last         = out_row_last && edge_pos && out_ch_wrap;
  end

  // line store
  logic [SW-1:0] top_data, mid_data;

  sem_line_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk         (clk),
    .rd_en       (accept && !drop),
    .rd_top_addr ({in_row_r[0], in_col_r, in_ch_r}),
    .rd_mid_addr ({~in_row_r[0], in_col_r, in_ch_r}),
    .rd_top_data (top_data),
    .rd_mid_data (mid_data),
    .wr_en       (state_r == ST_MEM),
    .wr_addr     (wr_addr_r),
    .wr_data     (s_r)
  );

  // square root unit
  logic              root_done;
  logic [sem_pkg::ROOT_W-1:0] root;

  sem_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_START),
    .value (sq_r),
    .done  (root_done),
    .root  (root)
  );

  // gradient from the updated window with border replication
  logic [SW-1:0] v [3][3];
  logic signed [GW-1:0] gx, gy;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v[r][c] = '0;
      end
    end
    for (int c = 0; c < 3; c++) begin
      v[0][c] = tdup_r ? win_r[ch_r][1][c] : win_r[ch_r][0][c];
      v[1][c] = win_r[ch_r][1][c];
      v[2][c] = bdup_r ? win_r[ch_r][1][c] : win_r[ch_r][2][c];
    end
    // columns: left may repeat middle, right repeats middle at row end
    for (int r = 0; r < 3; r++) begin
      v[r][0] = ldup_r ? v[r][1] : v[r][0];
      v[r][2] = edge_r ? v[r][1] : v[r][2];
    end
    gx = (GW'(v[0][2]) + (GW'(v[1][2]) << 1) + GW'(v[2][2]))
       - (GW'(v[0][0]) + (GW'(v[1][0]) << 1) + GW'(v[2][0]));
    gy = (GW'(v[2][0]) + (GW'(v[2][1]) << 1) + GW'(v[2][2]))
       - (GW'(v[0][0]) + (GW'(v[0][1]) << 1) + GW'(v[0][2]));
  end

  // squares
  logic signed [sem_pkg::SQ_W-1:0] gx_sq, gy_sq;
  logic        [sem_pkg::SQ_W-1:0] sq_sum;

  always_comb begin
    gx_sq  = gx_r * gx_r;
    gy_sq  = gy_r * gy_r;
    sq_sum = $unsigned(gx_sq) + $unsigned(gy_sq);
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // control, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= sem_pkg::RST_FRAME_WIDTH;
      fh_r        <= sem_pkg::RST_FRAME_HEIGHT;
      cc_r        <= sem_pkg::RST_CHANNEL_COUNT;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_ch_r     <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_ch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result beat taken and nothing new loaded
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            unique case (cfg_index)
              sem_pkg::REG_FRAME_WIDTH:   fw_r <= cfg_wdata;
              sem_pkg::REG_FRAME_HEIGHT:  fh_r <= cfg_wdata;
              sem_pkg::REG_CHANNEL_COUNT: cc_r <= cfg_wdata[sem_pkg::CCNT_W-1:0];
              default: ;
            endcase
            if (cfg_index == sem_pkg::REG_FRAME_WIDTH ||
                cfg_index == sem_pkg::REG_FRAME_HEIGHT ||
                cfg_index == sem_pkg::REG_CHANNEL_COUNT) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_ch_r   <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              out_ch_r  <= '0;
            end
          end else if (accept && !drop) begin
            state_r <= ST_MEM;
            if (emit && last) begin
              // frame end restarts all positions
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_ch_r   <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              out_ch_r  <= '0;
            end else begin
              // input position advance
              if (in_ch_wrap) begin
                in_ch_r <= '0;
                if (in_col_wrap) begin
                  in_col_r <= '0;
                  in_row_r <= in_row_r + 1'b1;
                end else begin
                  in_col_r <= in_col_r + 1'b1;
                end
              end else begin
                in_ch_r <= in_ch_r + 1'b1;
              end
              // output position advance
              if (emit) begin
                if (out_ch_wrap) begin
                  out_ch_r <= '0;
                  if (edge_pos) begin
                    out_col_r <= '0;
                    out_row_r <= out_row_r + 1'b1;
                  end else begin
                    out_col_r <= out_col_r + 1'b1;
                  end
                end else begin
                  out_ch_r <= out_ch_r + 1'b1;
                end
              end
            end
          end
        end
        ST_MEM:   state_r <= emit_r ? ST_GRAD : ST_IDLE;
        ST_GRAD:  state_r <= ST_SQ;
        ST_SQ:    state_r <= ST_START;
        ST_START: state_r <= ST_ROOT;
        ST_ROOT: begin
          if (root_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_mag_r       <= sat_r ? '1 : root;
            out_frame_end_r <= last_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // capture of the beat's context
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && !drop) begin
      s_r       <= in_frame ? in_sample : '0;
      ch_r      <= in_ch_r;
      wr_addr_r <= {in_row_r[0], in_col_r, in_ch_r};
      emit_r    <= emit;
      edge_r    <= edge_pos;
      ldup_r    <= out_col_r == '0;
      tdup_r    <= out_row_r == '0;
      bdup_r    <= out_row_last;
      last_r    <= last;
    end
  end

  // window shift for the beat's channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_r[k][r][c] <= '0;
          end
        end
      end
    end else if (state_r == ST_MEM) begin
      for (int r = 0; r < 3; r++) begin
        win_r[ch_r][r][0] <= win_r[ch_r][r][1];
        win_r[ch_r][r][1] <= win_r[ch_r][r][2];
      end
      win_r[ch_r][0][2] <= top_data;
      win_r[ch_r][1][2] <= mid_data;
      win_r[ch_r][2][2] <= s_r;
    end
  end

  // gradient and square registers
  always_ff @(posedge clk) begin
    if (state_r == ST_GRAD) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (state_r == ST_SQ) begin
      sq_r  <= sq_sum[sem_pkg::RAD_W-1:0];
      sat_r <= sq_sum[sem_pkg::SQ_W-1:sem_pkg::RAD_W] != '0;
    end
  end

  assign in_stall      = state_r != ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_frame_end = out_frame_end_r;

  // checks
  `SEM_ASSERT_ALWAYS(a_in_col_range, (WEFF_W)'(in_col_r) < w_eff, "input column out of range")
  `SEM_ASSERT_ALWAYS(a_out_ch_range, (CEFF_W)'(out_ch_r) < c_eff, "output channel out of range")
  `SEM_ASSERT_IMPL(a_load_from_out, out_valid_r && !$past(out_valid_r), $past(state_r) == ST_OUT, "result loaded outside output step")

endmodule

`default_nettype wire

// File: tb/sobel_edge_magnitude_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel edge magnitude checker
// watches the config port and the input and output ports and predicts every gradient
// magnitude. results are compared in order and mismatches are counted.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [sem_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [sem_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                         in_drain,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [sem_pkg::SAMPLE_W-1:0] out_magnitude,
  input  wire logic                         out_frame_end,
  output int                                fail_count,
  output int                                pending,
  output int                                frames_predicted
);

  localparam int MAXW  = sem_pkg::DEF_MAX_WIDTH;
  localparam int MAXC  = sem_pkg::DEF_MAX_CHANNELS;
  localparam int SPAN  = MAXW * MAXC;
  localparam int KX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KY [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  typedef struct packed {
    logic [sem_pkg::SAMPLE_W-1:0] magnitude;
    logic                         frame_end;
  } edge_beat_t;

  edge_beat_t expected_edges[$];

  logic [sem_pkg::SAMPLE_W-1:0] line_mem [0:2*SPAN-1];
  logic [sem_pkg::SAMPLE_W-1:0] win [0:MAXC-1][0:2][0:2];
  logic [sem_pkg::CFG_W-1:0]    fw, fh;
  logic [sem_pkg::CCNT_W-1:0]   cc;
  int unsigned                  icol, irow, ich, ocol, orow, och;

  function automatic int unsigned width_eff();
    if (fw < 1) return 1;
    if (fw > MAXW) return MAXW;
    return 32'(fw);
  endfunction

  function automatic int unsigned chan_eff();
    if (cc < 1) return 1;
    if (cc > MAXC) return MAXC;
    return 32'(cc);
  endfunction

  function automatic void restart_frame();
    icol = 0; irow = 0; ich = 0;
    ocol = 0; orow = 0; och = 0;
  endfunction

  // 3x3 gradient with replicated borders, floor of root, saturated
  function automatic logic [7:0] grad_mag(int ch, int l, int m, int r, int unsigned h);
    int rsel [3];
    int csel [3];
    int gx, gy, t;
    int unsigned sq;
    logic [7:0] root;
    rsel[0] = (orow == 0) ? 1 : 0;
    rsel[1] = 1;
    rsel[2] = (orow + 1 >= h) ? 1 : 2;
    csel[0] = (ocol == 0) ? m : l;
    csel[1] = m;
    csel[2] = r;
    gx = 0;
    gy = 0;
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) begin
        gx += int'(win[ch][rsel[j]][csel[i]]) * KX[j][i];
        gy += int'(win[ch][rsel[j]][csel[i]]) * KY[j][i];
      end
    sq = gx * gx + gy * gy;
    if (sq >= 65536) return 8'hff;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      t = root | (1 << b);
      if (t * t <= sq) root = 8'(t);
    end
    return root;
  endfunction

  // one accepted input beat through the predictor
  function automatic void predict_beat(logic [7:0] smp, logic drn);
    int unsigned w, h, c, ch, top_i, mid_i;
    logic emit, at_edge, last;
    logic [7:0] mag, top_v, mid_v, s;
    w = width_eff();
    h = (fh < 1) ? 1 : 32'(fh);
    c = chan_eff();
    s = smp;
    mag = 0;
    if (irow < h && drn) return;
    if (irow >= h) s = 0;
    if (icol >= w) icol = w - 1;
    if (ich >= c) ich = c - 1;
    ch = ich;
    emit = (irow > 1) || (irow == 1 && icol >= 1);
    at_edge = (ocol + 1 >= w);
    if (emit && at_edge) mag = grad_mag(ch, 1, 2, 2, h);
    top_i = (irow & 1) * SPAN + icol * MAXC + ch;
    mid_i = ((irow + 1) & 1) * SPAN + icol * MAXC + ch;
    top_v = line_mem[top_i];
    mid_v = line_mem[mid_i];
    for (int r = 0; r < 3; r++) begin
      win[ch][r][0] = win[ch][r][1];
      win[ch][r][1] = win[ch][r][2];
    end
    win[ch][0][2] = top_v;
    win[ch][1][2] = mid_v;
    win[ch][2][2] = s;
    line_mem[top_i] = s;
    if (emit && !at_edge) mag = grad_mag(ch, 0, 1, 2, h);
    if (++ich >= c) begin
      ich = 0;
      if (++icol >= w) begin
        icol = 0;
        irow++;
      end
    end
    if (!emit) return;
    last = (orow + 1 >= h) && at_edge && (och + 1 >= c);
    expected_edges.push_back('{magnitude: mag, frame_end: last});
    if (last) begin
      restart_frame();
      frames_predicted++;
    end else if (++och >= c) begin
      och = 0;
      if (++ocol >= w) begin
        ocol = 0;
        orow++;
      end
    end
  endfunction

  initial begin
    fail_count = 0;
    frames_predicted = 0;
    for (int i = 0; i < 2 * SPAN; i++) line_mem[i] = '0;
  end

  assign pending = expected_edges.size();

  // compare, then track config and input beats
  always @(posedge clk) begin
    edge_beat_t exp_b;
    if (!rst_n) begin
      fw = sem_pkg::RST_FRAME_WIDTH;
      fh = sem_pkg::RST_FRAME_HEIGHT;
      cc = sem_pkg::RST_CHANNEL_COUNT;
      restart_frame();
      for (int k = 0; k < MAXC; k++)
        for (int r = 0; r < 3; r++)
          for (int q = 0; q < 3; q++) win[k][r][q] = '0;
      expected_edges.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: magnitude=%0d frame_end=%0b",
                     out_magnitude, out_frame_end);
        end else begin
          exp_b = expected_edges.pop_front();
          if (exp_b.magnitude !== out_magnitude || exp_b.frame_end !== out_frame_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected magnitude=%0d frame_end=%0b, got %0d/%0b",
                       exp_b.magnitude, exp_b.frame_end, out_magnitude, out_frame_end);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          sem_pkg::REG_FRAME_WIDTH: begin
            fw = cfg_wdata;
            restart_frame();
          end
          sem_pkg::REG_FRAME_HEIGHT: begin
            fh = cfg_wdata;
            restart_frame();
          end
          sem_pkg::REG_CHANNEL_COUNT: begin
            cc = cfg_wdata[sem_pkg::CCNT_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_beat(in_sample, in_drain);
    end
  end

endmodule

`default_nettype wire

// File: tb/sobel_edge_magnitude_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel edge magnitude testbench
// drives small frames of many shapes with random gaps and stalls, plus a long
// receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_tb;

  localparam sem_pkg::cfg_idx_t REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 24;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [1:0]                   cfg_index;
  logic [sem_pkg::CFG_W-1:0]    cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [sem_pkg::SAMPLE_W-1:0] in_sample;
  logic                         in_drain;
  logic                         out_valid;
  logic                         out_stall;
  logic [sem_pkg::SAMPLE_W-1:0] out_magnitude;
  logic                         out_frame_end;

  int fail_count, pending, frames_predicted;
  int send_idle_pct, stall_pct;
  int hold_cycles, quiet_cycles, samples_sent;
  bit hold_req;

  sobel_edge_magnitude uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample), .in_drain(in_drain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_magnitude(out_magnitude), .out_frame_end(out_frame_end)
  );

  sobel_edge_magnitude_checker edge_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample), .in_drain(in_drain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_magnitude(out_magnitude), .out_frame_end(out_frame_end),
    .fail_count(fail_count), .pending(pending), .frames_predicted(frames_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stall, with a long hold-off on request
  initial hold_cycles = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cycles = 300;
      hold_req = 1'b0;
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no beat and no register write
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one input beat, entered and left at a falling edge
  task automatic send_beat(input logic [7:0] smp, input logic drn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_drain  <= drn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // enable stays high across back-to-back writes, set_frame drops it
  task automatic write_reg(input sem_pkg::cfg_idx_t idx,
                           input logic [sem_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int c);
    write_reg(sem_pkg::REG_FRAME_WIDTH, sem_pkg::CFG_W'(w));
    write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::CFG_W'(h));
    write_reg(sem_pkg::REG_CHANNEL_COUNT, sem_pkg::CFG_W'(c));
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, sem_pkg::CFG_W'($urandom));
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // samples of one frame, then flush until the final result is predicted;
  // a nonzero cut stops after that many samples and leaves the frame open
  task automatic run_frame(input int w, input int h, input int c, input int pattern,
                           input int cut);
    int n, done_before;
    logic [7:0] s;
    n = w * h * c;
    if (cut > 0 && cut < n) n = cut;
    done_before = frames_predicted;
    for (int k = 0; k < n; k++) begin
      // stray drain inside the frame is dropped
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b1);
      case (pattern)
        1: s = 8'h00;
        2: s = 8'hff;
        3: s = (((k / c) + (k / (w * c))) & 1) ? 8'hff : 8'h00;
        4: s = $urandom_range(1) ? 8'hff : 8'h00;
        default: s = 8'($urandom);
      endcase
      send_beat(s, 1'b0);
      samples_sent++;
    end
    if (cut > 0) return;
    // flush, sometimes with samples that only count as drain beats
    while (frames_predicted == done_before) begin
      if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0);
      else send_beat(8'($urandom), 1'b1);
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stalls, input int goal);
    int w, h, c, target;
    send_idle_pct = idle_pct;
    stall_pct = stalls;
    target = samples_sent + goal;
    while (samples_sent < target) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      c = $urandom_range(1, 4);
      if ($urandom_range(7) == 0) c = $urandom_range(0, 7);
      if ($urandom_range(9) == 0) w = 0;
      if ($urandom_range(9) == 0) h = 0;
      set_frame(w, h, c);
      w = (w < 1) ? 1 : w;
      h = (h < 1) ? 1 : h;
      c = (c < 1) ? 1 : ((c > 4) ? 4 : c);
      run_frame(w, h, c, ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0,
                ($urandom_range(9) == 0) ? $urandom_range(1, w * h * c) : 0);
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_drain = 1'b0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    samples_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: tiny frames, saturating checkerboard, clamped registers
    set_frame(3, 3, 1);
    run_frame(3, 3, 1, 3, 0);
    wait_idle();
    set_frame(1, 1, 1);
    run_frame(1, 1, 1, 2, 0);
    wait_idle();
    set_frame(0, 0, 0);
    run_frame(1, 1, 1, 0, 0);
    wait_idle();
    set_frame(2, 1, 7);
    run_frame(2, 1, 4, 4, 0);
    wait_idle();
    // huge height, restarted after a few samples
    set_frame(2, 8191, 1);
    run_frame(2, 8191, 1, 0, 3);
    wait_idle();

    // random frames through the idle and stall mixes
    random_phase(0, 0, 45);
    random_phase(74, 0, 45);
    random_phase(0, 74, 45);
    random_phase(21, 21, 45);

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    stall_pct = 0;
    set_frame(6, 5, 4);
    hold_req = 1'b1;
    run_frame(6, 5, 4, 0, 0);
    wait_idle();

    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
